// File: rtl/sflr_pkg.sv
// ----------------------------------------------------------------------------
// sflr_pkg
// Shared types and constants of the start/length/CRC/end frame receiver.
// ----------------------------------------------------------------------------
package sflr_pkg;

  localparam logic [15:0] FrameOverhead = 16'd9;
  localparam logic [1:0]  CrcLastSel    = 2'd3;

  localparam logic [1:0] CfgStartByte   = 2'd0;
  localparam logic [1:0] CfgEndByte     = 2'd1;
  localparam logic [1:0] CfgMaxFrameLen = 2'd2;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_START = 3'd1,
    ERR_END   = 3'd2,
    ERR_RX    = 3'd3,
    ERR_LONG  = 3'd4
  } err_code_e;

  typedef enum logic [2:0] {
    CMD_IDLE = 3'd0,
    CMD_TYPE = 3'd1,
    CMD_DATA = 3'd2,
    CMD_CRC  = 3'd3,
    CMD_DONE = 3'd4
  } cmd_kind_e;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [15:0] max_frame_len;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic        last;
    logic [1:0]  crc_sel;
    err_code_e   code;
    logic [15:0] length;
  } cmd_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic        frame_done;
    logic        frame_ok;
    logic [2:0]  error_code;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic [31:0] frame_crc;
  } res_t;

endpackage

// File: rtl/sflr_if.sv
// ----------------------------------------------------------------------------
// sflr interfaces
// Byte, result and configuration channels of the frame receiver.
// ----------------------------------------------------------------------------
interface sflr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rx_error;

  modport source (output valid, output rx_byte, output rx_error, input ready);
  modport sink   (input valid, input rx_byte, input rx_error, output ready);
endinterface

interface sflr_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        payload_last;
  logic        frame_done;
  logic        frame_ok;
  logic [2:0]  error_code;
  logic [7:0]  frame_type;
  logic [15:0] frame_length;
  logic [31:0] frame_crc;

  modport source (
    output valid, output payload_valid, output payload_byte, output payload_last,
    output frame_done, output frame_ok, output error_code, output frame_type,
    output frame_length, output frame_crc, input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_byte, input payload_last,
    input frame_done, input frame_ok, input error_code, input frame_type,
    input frame_length, input frame_crc, output ready
  );
endinterface

interface sflr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/sflr_front.sv
// ----------------------------------------------------------------------------
// sflr_front
// Frame parser: tracks the frame phase per byte beat and issues one command.
// ----------------------------------------------------------------------------
module sflr_front
  import sflr_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cfg_t           cfg_i,
  sflr_in_if.sink        in_i,
  output logic           cmd_valid_o,
  output cmd_t           cmd_o,
  input  logic           cmd_ready_i
);

  localparam logic [2:0] PhSof  = 3'd0;
  localparam logic [2:0] PhType = 3'd1;
  localparam logic [2:0] PhLen  = 3'd2;
  localparam logic [2:0] PhData = 3'd3;
  localparam logic [2:0] PhCrc  = 3'd4;
  localparam logic [2:0] PhEof  = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [1:0]  sub_q, sub_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic        over_q, over_d;
  logic        push;
  logic [15:0] len_full;
  logic        last;
  cmd_t        cmd;

  assign in_i.ready  = cmd_ready_i;
  assign push        = in_i.valid && cmd_ready_i;
  assign cmd_valid_o = in_i.valid;
  assign cmd_o       = cmd;
  assign len_full    = {in_i.rx_byte, len_q[7:0]};
  assign last        = ({1'b0, cnt_q} + 17'd1) >= {1'b0, len_q};

  always_comb begin
    phase_d     = phase_q;
    sub_d       = sub_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    over_d      = over_q;
    cmd.kind    = CMD_IDLE;
    cmd.data    = in_i.rx_byte;
    cmd.last    = 1'b0;
    cmd.crc_sel = sub_q;
    cmd.code    = ERR_NONE;
    cmd.length  = '0;
    if (in_i.rx_error) begin
      cmd.kind = CMD_DONE;
      cmd.code = ERR_RX;
    end else begin
      case (phase_q)
        PhSof: begin
          if (in_i.rx_byte != cfg_i.start_byte) begin
            cmd.kind = CMD_DONE;
            cmd.code = ERR_START;
          end else begin
            phase_d = PhType;
          end
        end
        PhType: begin
          cmd.kind = CMD_TYPE;
          phase_d  = PhLen;
          sub_d    = 2'd0;
        end
        PhLen: begin
          if (sub_q == 2'd0) begin
            len_d = {8'd0, in_i.rx_byte};
            sub_d = 2'd1;
          end else begin
            len_d   = len_full;
            over_d  = ({1'b0, len_full} + {1'b0, FrameOverhead}) >
                      {1'b0, cfg_i.max_frame_len};
            sub_d   = 2'd0;
            cnt_d   = '0;
            phase_d = (len_full == 16'd0) ? PhCrc : PhData;
          end
        end
        PhData: begin
          if (!over_q) begin
            cmd.kind = CMD_DATA;
            cmd.last = last;
          end
          cnt_d = cnt_q + 16'd1;
          if (last) begin
            phase_d = PhCrc;
            sub_d   = 2'd0;
          end
        end
        PhCrc: begin
          cmd.kind = CMD_CRC;
          sub_d    = sub_q + 2'd1;
          if (sub_q == CrcLastSel) begin
            phase_d = PhEof;
          end
        end
        PhEof: begin
          cmd.kind = CMD_DONE;
          if (in_i.rx_byte != cfg_i.end_byte) begin
            cmd.code = ERR_END;
          end else if (over_q) begin
            cmd.code = ERR_LONG;
          end else begin
            cmd.length = len_q + FrameOverhead;
          end
        end
        default: begin
          phase_d = PhSof;
          sub_d   = '0;
          len_d   = '0;
          cnt_d   = '0;
          over_d  = 1'b0;
        end
      endcase
    end
    if (cmd.kind == CMD_DONE) begin
      phase_d = PhSof;
      sub_d   = '0;
      len_d   = '0;
      cnt_d   = '0;
      over_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSof;
      sub_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      over_q  <= 1'b0;
    end else if (push) begin
      phase_q <= phase_d;
      sub_q   <= sub_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      over_q  <= over_d;
    end
  end

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && cmd.kind == CMD_DONE |=> phase_q == PhSof && !over_q && cnt_q == 16'd0)
    else $error("frame state not cleared after frame end");

  a_data_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && cmd.kind == CMD_DATA |-> phase_q == PhData && !over_q)
    else $error("payload beat outside an in-limit data phase");

  a_data_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhData |-> len_q != 16'd0)
    else $error("data phase entered with zero length");

endmodule

// File: rtl/sflr_fifo.sv
// ----------------------------------------------------------------------------
// sflr_fifo
// Command queue between parser and result builder.
// ----------------------------------------------------------------------------
module sflr_fifo
  import sflr_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = cnt_q != CntFull;
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/sflr_back.sv
// ----------------------------------------------------------------------------
// sflr_back
// Result builder: holds type and CRC word, forms one result per command.
// ----------------------------------------------------------------------------
module sflr_back
  import sflr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  input  cmd_t       cmd_i,
  sflr_out_if.source out_o
);

  logic [7:0]  type_q, type_d;
  logic [31:0] crc_q, crc_d;
  logic        out_valid_q;
  res_t        res_q, res_d;
  logic        pop;

  assign cmd_ready_o = !out_valid_q || out_o.ready;
  assign pop         = cmd_valid_i && cmd_ready_o;

  always_comb begin
    type_d = type_q;
    crc_d  = crc_q;
    res_d  = '0;
    case (cmd_i.kind)
      CMD_TYPE: type_d = cmd_i.data;
      CMD_CRC:  crc_d  = crc_q | ({24'd0, cmd_i.data} << {cmd_i.crc_sel, 3'b000});
      CMD_DATA: begin
        res_d.payload_valid = 1'b1;
        res_d.payload_byte  = cmd_i.data;
        res_d.payload_last  = cmd_i.last;
      end
      CMD_DONE: begin
        res_d.frame_done   = 1'b1;
        res_d.frame_ok     = cmd_i.code == ERR_NONE;
        res_d.error_code   = cmd_i.code;
        res_d.frame_type   = type_q;
        res_d.frame_length = cmd_i.length;
        res_d.frame_crc    = crc_q;
        type_d             = '0;
        crc_d              = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q      <= '0;
      crc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        type_q      <= type_d;
        crc_q       <= crc_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.payload_valid = res_q.payload_valid;
  assign out_o.payload_byte  = res_q.payload_byte;
  assign out_o.payload_last  = res_q.payload_last;
  assign out_o.frame_done    = res_q.frame_done;
  assign out_o.frame_ok      = res_q.frame_ok;
  assign out_o.error_code    = res_q.error_code;
  assign out_o.frame_type    = res_q.frame_type;
  assign out_o.frame_length  = res_q.frame_length;
  assign out_o.frame_crc     = res_q.frame_crc;

endmodule

// File: rtl/sof_len_crc_eof_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// sof_len_crc_eof_frame_receiver_core
// Deframer for start/type/length/payload/CRC/end frames, one result per byte.
// ----------------------------------------------------------------------------
//  channel  dir  beat
//  in_i     in   rx_byte, rx_error
//  out_o    out  payload and frame-end result fields
//  cfg_i    in   index, data (start byte, end byte, max frame length)
//
//  Takes one byte per cycle while the queue has room; one result beat per byte.
//  The parser feeds a command queue of QueueDepth entries, the result builder
//  drains it into an output register; either side stalls without the other.
//  Reset loads the default start byte, end byte and max length; no clear pass.
//  Configuration writes are always ready.
// ----------------------------------------------------------------------------
module sof_len_crc_eof_frame_receiver_core
  import sflr_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sflr_in_if.sink    in_i,
  sflr_out_if.source out_o,
  sflr_cfg_if.sink   cfg_i
);

  cfg_t cfg_q;
  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic back_valid, back_ready;
  cmd_t back_cmd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte    <= 8'd170;
      cfg_q.end_byte      <= 8'd187;
      cfg_q.max_frame_len <= 16'd1033;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgStartByte:   cfg_q.start_byte    <= cfg_i.data[7:0];
        CfgEndByte:     cfg_q.end_byte      <= cfg_i.data[7:0];
        CfgMaxFrameLen: cfg_q.max_frame_len <= cfg_i.data;
        default: ;
      endcase
    end
  end

  sflr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_i),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd),
    .cmd_ready_i (front_ready)
  );

  sflr_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_cmd)
  );

  sflr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .out_o       (out_o)
  );

endmodule
